// ----- src/q4dot_pkg.sv -----
// Shared types and constants for the Q4 block dot product.
`default_nettype none
package q4dot_pkg;

    // Block geometry: 32 weights per block, split over four lanes
    localparam int unsigned BLOCK_SIZE     = 32;
    localparam int unsigned LANES          = 4;
    localparam int unsigned ACTS_PER_LANE  = BLOCK_SIZE / LANES;
    localparam int unsigned QBYTES_PER_LANE = ACTS_PER_LANE / 2;

    // Datapath widths
    localparam int unsigned ACT_W   = 8;
    localparam int unsigned NIB_W   = 4;
    localparam int unsigned WGT_W   = NIB_W + 1;
    localparam int unsigned LPROD_W = WGT_W + ACT_W;
    localparam int unsigned LANE_W  = 15;   // sum of 8 products of 5b x 8b signed
    localparam int unsigned DOT_W   = 17;   // sum of 32 products, |dot| <= 32768
    localparam int unsigned MANT_W  = 11;   // half mantissa with hidden bit
    localparam int unsigned PROD_W  = 28;   // signed mantissa x dot
    localparam int unsigned SHIFT_W = 5;
    localparam int unsigned ACC_W   = 64;

    // Half-precision field codes
    localparam logic [4:0]         EXP_ALL_ONES = 5'h1F;
    localparam logic [4:0]         EXP_ZERO     = 5'h00;
    localparam logic signed [WGT_W-1:0] NIB_BIAS = 5'sd8;

    // Saturation limits of the row sum
    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Input word: one quantized weight block with its activations
    typedef struct packed {
        logic [15:0] scale_half;
        logic [63:0] quant_bytes_low;
        logic [63:0] quant_bytes_high;
        logic [63:0] acts_a;
        logic [63:0] acts_b;
        logic [63:0] acts_c;
        logic [63:0] acts_d;
        logic        row_end;
    } t_in_word;

    // Output word: one finished row
    typedef struct packed {
        logic signed [63:0] row_sum;
        logic               saturated;
        logic               bad_scale;
    } t_out_word;

    // Per-lane partial sums
    typedef logic [LANES-1:0][LANE_W-1:0] t_lane_vec;

    // Decoded scale and row control, first pipeline stage
    typedef struct packed {
        logic [MANT_W-1:0]  mant;
        logic [SHIFT_W-1:0] shift;
        logic               sign;
        logic               bad;
        logic               row_end;
    } t_blk_ctl;

    // Scaled product and row control, second pipeline stage
    typedef struct packed {
        logic signed [PROD_W-1:0] prod;
        logic [SHIFT_W-1:0]       shift;
        logic                     sign;
        logic                     bad;
        logic                     row_end;
    } t_prod_ctl;

endpackage
`default_nettype wire

// ----- src/q4dot_lane.sv -----
// One lane: eight 4-bit weight by 8-bit activation products, summed and registered.
`default_nettype none
module q4dot_lane (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_en,
    input  wire logic [8*q4dot_pkg::QBYTES_PER_LANE-1:0] i_qbytes,
    input  wire logic [8*q4dot_pkg::ACTS_PER_LANE-1:0]   i_acts,
    output logic      [q4dot_pkg::LANE_W-1:0]            o_sum
);

    logic [q4dot_pkg::LANE_W-1:0] n_sum;
    logic [q4dot_pkg::LANE_W-1:0] r_sum;

    // Even elements take the low nibble, odd ones the high nibble
    always_comb begin
        logic [7:0]                                q;
        logic [q4dot_pkg::NIB_W-1:0]               nib;
        logic signed [q4dot_pkg::WGT_W-1:0]        w;
        logic signed [q4dot_pkg::ACT_W-1:0]        a;
        logic signed [q4dot_pkg::LPROD_W-1:0]      p;
        logic signed [q4dot_pkg::LANE_W-1:0]       s;
        s = '0;
        for (int e = 0; e < int'(q4dot_pkg::ACTS_PER_LANE); e++) begin
            q   = i_qbytes[(e >> 1) * 8 +: 8];
            nib = e[0] ? q[7:4] : q[3:0];
            w   = $signed({1'b0, nib}) - q4dot_pkg::NIB_BIAS;
            a   = $signed(i_acts[e * q4dot_pkg::ACT_W +: q4dot_pkg::ACT_W]);
            p   = w * a;
            s   = s + q4dot_pkg::LANE_W'(p);
        end
        n_sum = s;
    end

    // Lane result register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule
`default_nettype wire

// ----- src/q4dot_merge.sv -----
// Merge stage: adds the lane sums into the block dot and scales it by the mantissa.
`default_nettype none
module q4dot_merge (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire q4dot_pkg::t_lane_vec i_lanes,
    input  wire q4dot_pkg::t_blk_ctl  i_ctl,
    output logic                      o_valid,
    output q4dot_pkg::t_prod_ctl      o_prod
);

    logic                 r_valid;
    q4dot_pkg::t_prod_ctl r_prod;
    q4dot_pkg::t_prod_ctl n_prod;

    // Lane sum tree and the single mantissa multiply
    always_comb begin
        logic signed [q4dot_pkg::DOT_W-1:0] dot;
        dot = '0;
        for (int k = 0; k < int'(q4dot_pkg::LANES); k++) begin
            dot = dot + q4dot_pkg::DOT_W'($signed(i_lanes[k]));
        end
        n_prod.prod    = $signed({1'b0, i_ctl.mant}) * dot;
        n_prod.shift   = i_ctl.shift;
        n_prod.sign    = i_ctl.sign;
        n_prod.bad     = i_ctl.bad;
        n_prod.row_end = i_ctl.row_end;
    end

    // Stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule
`default_nettype wire

// ----- src/q4dot_accum.sv -----
// Row accumulator: exponent shift, sign, saturating add and the output register.
`default_nettype none
module q4dot_accum (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire q4dot_pkg::t_prod_ctl i_prod,
    output logic                      o_valid,
    output q4dot_pkg::t_out_word      o_word
);

    logic [q4dot_pkg::ACC_W-1:0] r_acc;
    logic                        r_sat;
    logic                        r_bad;
    logic                        r_out_valid;
    q4dot_pkg::t_out_word        r_out;

    logic [q4dot_pkg::ACC_W-1:0] n_acc;
    logic                        n_sat;
    logic                        n_bad;

    // Contribution in units of 2^-24, then saturating add
    always_comb begin
        logic signed [q4dot_pkg::ACC_W-1:0] mag;
        logic signed [q4dot_pkg::ACC_W-1:0] contrib;
        logic [q4dot_pkg::ACC_W-1:0]        sum;
        logic                               ovf;
        mag     = q4dot_pkg::ACC_W'(i_prod.prod) << i_prod.shift;
        contrib = i_prod.sign ? -mag : mag;
        sum     = r_acc + contrib;
        ovf     = (r_acc[q4dot_pkg::ACC_W-1] == contrib[q4dot_pkg::ACC_W-1]) &&
                  (sum[q4dot_pkg::ACC_W-1] != contrib[q4dot_pkg::ACC_W-1]);
        if (ovf) begin
            n_acc = contrib[q4dot_pkg::ACC_W-1] ? q4dot_pkg::ACC_MIN : q4dot_pkg::ACC_MAX;
        end else begin
            n_acc = sum;
        end
        n_sat = r_sat | ovf;
        n_bad = r_bad | i_prod.bad;
    end

    // Row state; clears after the row's last block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_sat       <= 1'b0;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= i_valid & i_prod.row_end;
            if (i_valid) begin
                if (i_prod.row_end) begin
                    r_acc <= '0;
                    r_sat <= 1'b0;
                    r_bad <= 1'b0;
                end else begin
                    r_acc <= n_acc;
                    r_sat <= n_sat;
                    r_bad <= n_bad;
                end
            end
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (i_en && i_valid && i_prod.row_end) begin
            r_out.row_sum   <= $signed(n_acc);
            r_out.saturated <= n_sat;
            r_out.bad_scale <= n_bad;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

endmodule
`default_nettype wire

// ----- src/q4_block_dot_product.sv -----
// Q4 block dot product with row accumulation: top level.
//
// Input channel: one word per 32-weight block (half scale, 16 quant bytes,
// 32 signed 8-bit activations, row_end). A word is taken at a clock edge
// with i_valid high and o_stall low.
// Output channel: one word per row, only for a block with row_end set,
// holding the saturated 64-bit row sum (24 fraction bits) and the sticky
// saturation and bad-scale flags of that row. Taken when o_valid is high
// and i_stall is low.
// A row result passes through the lane product, merge and multiply, and
// accumulate registers after the edge that takes its last block.
// Throughput: one block per cycle unless stalled, set by the four
// product lanes working on a whole block at once and a single accumulator
// add per cycle. When the receiver stalls with a result waiting, the whole
// pipeline holds and o_stall goes high until that result is taken.
// Reset (i_rst_n low, synchronous) empties the pipeline and clears the
// accumulator and both row flags.
`default_nettype none
module q4_block_dot_product (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire q4dot_pkg::t_in_word  i_data,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output q4dot_pkg::t_out_word      o_data
);

    logic                 w_en;
    logic [4*64-1:0]      w_acts;
    logic [2*64-1:0]      w_qbytes;
    q4dot_pkg::t_lane_vec w_lanes;
    q4dot_pkg::t_blk_ctl  n_ctl;
    q4dot_pkg::t_blk_ctl  r_ctl;
    logic                 r_valid;
    logic                 w_mrg_valid;
    q4dot_pkg::t_prod_ctl w_prod;

    // Pipeline advances unless a result waits on a stalled receiver
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    assign w_acts   = {i_data.acts_d, i_data.acts_c, i_data.acts_b, i_data.acts_a};
    assign w_qbytes = {i_data.quant_bytes_high, i_data.quant_bytes_low};

    // Product lanes, eight activations each
    for (genvar k = 0; k < int'(q4dot_pkg::LANES); k++) begin : g_lane
        q4dot_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_qbytes (w_qbytes[k*8*q4dot_pkg::QBYTES_PER_LANE +:
                                8*q4dot_pkg::QBYTES_PER_LANE]),
            .i_acts   (w_acts[k*8*q4dot_pkg::ACTS_PER_LANE +:
                              8*q4dot_pkg::ACTS_PER_LANE]),
            .o_sum    (w_lanes[k])
        );
    end

    // Half scale decode: mantissa with hidden bit and exponent shift
    always_comb begin
        logic [4:0] e;
        logic [9:0] m;
        e = i_data.scale_half[14:10];
        m = i_data.scale_half[9:0];
        n_ctl.bad     = (e == q4dot_pkg::EXP_ALL_ONES);
        n_ctl.sign    = i_data.scale_half[15];
        n_ctl.row_end = i_data.row_end;
        if (n_ctl.bad) begin
            n_ctl.mant  = '0;
            n_ctl.shift = '0;
        end else if (e == q4dot_pkg::EXP_ZERO) begin
            n_ctl.mant  = {1'b0, m};
            n_ctl.shift = '0;
        end else begin
            n_ctl.mant  = {1'b1, m};
            n_ctl.shift = e - 5'd1;
        end
    end

    // First stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    // First stage control payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ctl <= n_ctl;
        end
    end

    q4dot_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_valid),
        .i_lanes (w_lanes),
        .i_ctl   (r_ctl),
        .o_valid (w_mrg_valid),
        .o_prod  (w_prod)
    );

    q4dot_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_mrg_valid),
        .i_prod  (w_prod),
        .o_valid (o_valid),
        .o_word  (o_data)
    );

endmodule
`default_nettype wire
